/* rtl/acfd_pkg.sv */
// Shared types, register indexes, result codes and the CRC-8 byte update of the frame decoder.
package acfd_pkg;

   // Register indexes, taken from address bit 2 of the configuration port.
   localparam logic REG_STATUS_ENABLE = 1'b0;
   localparam logic REG_CRC_ENABLE    = 1'b1;

   // Result codes.
   localparam logic RESULT_OK           = 1'b0;
   localparam logic RESULT_CRC_MISMATCH = 1'b1;

   // CRC-8 generator x^8 + x^2 + x + 1, without the leading term.
   localparam logic [7:0] CRC_POLY = 8'h07;

   // Last byte position; the position counter saturates here.
   localparam logic [2:0] POS_LAST = 3'd7;

   // Frame layout switches.
   typedef struct packed {
      logic status_enable;
      logic crc_enable;
   } cfg_type;

   // One decoded frame result.
   typedef struct packed {
      logic [7:0]         status_byte;
      logic signed [23:0] sample;
      logic               result_code;
   } result_type;

   // Bytewise CRC-8 update, MSB first, no reflection.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/acfd_frame_parser.sv */
// Frame parser: byte position tracking, CRC accumulation, sample assembly and status keeping.
module acfd_frame_parser
   import acfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   input  logic       frame_first,
   input  logic       command_read,
   output logic       result_valid,
   output result_type result
);

   logic [2:0]  byte_position_ff, byte_position_in;
   logic        frame_mode_ff, frame_mode_in;
   logic [7:0]  crc_running_ff, crc_running_in;
   logic [23:0] data_shift_ff, data_shift_in;
   logic [7:0]  pending_status_ff, pending_status_in;
   logic [7:0]  stored_status_ff, stored_status_in;

   logic [2:0]  pos_base;
   logic [7:0]  crc_base;
   logic [23:0] data_base;
   logic [2:0]  q_index;
   logic [2:0]  d_index;
   logic        skip_byte;
   logic        emit;
   logic        code;

   // Classify the byte and work out the next state and any result.
   always_comb begin
      pos_base      = frame_first ? 3'd0 : byte_position_ff;
      frame_mode_in = frame_first ? command_read : frame_mode_ff;
      crc_base      = frame_first ? 8'h00 : crc_running_ff;
      data_base     = frame_first ? 24'h000000 : data_shift_ff;

      byte_position_in  = (pos_base != POS_LAST) ? pos_base + 3'd1 : pos_base;
      crc_running_in    = crc_base;
      data_shift_in     = data_base;
      pending_status_in = pending_status_ff;
      stored_status_in  = stored_status_ff;
      emit              = 1'b0;
      code              = RESULT_OK;

      skip_byte = (pos_base == 3'd0) && frame_mode_in;
      q_index   = pos_base - {2'b00, frame_mode_in};
      d_index   = q_index - {2'b00, cfg.status_enable};

      if (!skip_byte) begin
         if (cfg.status_enable && (q_index == 3'd0)) begin
            pending_status_in = rx_byte;
            crc_running_in    = crc8_byte(crc_base, rx_byte);
         end else if (d_index < 3'd3) begin
            data_shift_in  = {data_base[15:0], rx_byte};
            crc_running_in = crc8_byte(crc_base, rx_byte);
            emit           = (d_index == 3'd2) && !cfg.crc_enable;
         end else if ((d_index == 3'd3) && cfg.crc_enable) begin
            emit = 1'b1;
            code = (rx_byte != crc_base) ? RESULT_CRC_MISMATCH : RESULT_OK;
         end
      end

      // A frame that passes updates the kept status byte when the status byte is enabled.
      if (emit && (code == RESULT_OK) && cfg.status_enable) begin
         stored_status_in = pending_status_ff;
      end

      result.sample      = (code == RESULT_OK) ? data_shift_in : 24'sd0;
      result.status_byte = stored_status_in;
      result.result_code = code;
      result_valid       = byte_accept && emit;
   end

   // Frame state, advanced once per accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= 3'd0;
         frame_mode_ff     <= 1'b0;
         crc_running_ff    <= 8'h00;
         data_shift_ff     <= 24'h000000;
         pending_status_ff <= 8'h00;
         stored_status_ff  <= 8'h00;
      end else if (byte_accept) begin
         byte_position_ff  <= byte_position_in;
         frame_mode_ff     <= frame_mode_in;
         crc_running_ff    <= crc_running_in;
         data_shift_ff     <= data_shift_in;
         pending_status_ff <= pending_status_in;
         stored_status_ff  <= stored_status_in;
      end
   end

endmodule

/* rtl/adc_conversion_frame_decoder_top.sv */
// Top level of the converter frame decoder: channels, configuration registers and result buffering.
//
//  channel | direction | transfer payload
//  req_*   | in        | tdata[7:0] rx_byte; tuser[0] frame_first, tuser[1] command_read
//  rsp_*   | out       | tdata[23:0] sample, tdata[31:24] status_byte; tuser result_code
//  csr_*   | in        | APB-style writes and reads of status_enable (0x0) and crc_enable (0x4)
//
// One byte is taken per cycle while the skid register is free; a frame's result is registered in
// the output or skid register. The CRC-8 is updated a whole byte per cycle, so the rate is set by
// the single register stage of the parser. A two-entry output buffer (output register plus skid
// register) keeps req_tready independent of rsp_tready; input stalls only while both entries are
// full. Reset is synchronous and clears the frame state, the registers and the buffer.
module adc_conversion_frame_decoder_top
   import acfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [0] frame_first, [1] command_read
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] sample, [31:24] status_byte
   output logic        rsp_tuser,   // [0] result_code
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff;
   logic       byte_accept;
   logic       result_valid;
   result_type result;

   result_type out_data_ff;
   logic       out_valid_ff;
   result_type skid_data_ff;
   logic       skid_valid_ff;
   logic       out_take;

   // Configuration registers; bit 2 of the address selects the register.
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_STATUS_ENABLE: cfg_ff.status_enable <= csr_pwdata[0];
            REG_CRC_ENABLE:    cfg_ff.crc_enable    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_STATUS_ENABLE: csr_prdata = {31'd0, cfg_ff.status_enable};
         REG_CRC_ENABLE:    csr_prdata = {31'd0, cfg_ff.crc_enable};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Input transfers are taken whenever the skid register is free.
   assign req_tready  = !skid_valid_ff;
   assign byte_accept = req_tvalid && req_tready;

   acfd_frame_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .byte_accept  (byte_accept),
      .rx_byte      (req_tdata),
      .frame_first  (req_tuser[0]),
      .command_read (req_tuser[1]),
      .result_valid (result_valid),
      .result       (result)
   );

   // Output register with a skid register behind it.
   assign out_take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (result_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (result_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.status_byte, out_data_ff.sample};
   assign rsp_tuser  = out_data_ff.result_code;

endmodule

/* rtl/acfd_checker.sv */
// Port-level checks of the frame decoder and their binding to the top level.
module acfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_pready
);

   // A result held back by the receiver stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // A CRC mismatch always carries a zero sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[23:0] == 24'd0)
      else $error("mismatch result with non-zero sample");

   // Reset empties the result buffer.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // The configuration port never inserts wait states.
   assert property (@(posedge clock) csr_pready)
      else $error("configuration port not ready");

endmodule

bind adc_conversion_frame_decoder_top acfd_checker u_acfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

/* tb/adc_conversion_frame_decoder_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the converter frame decoder: directed frames, then randomised traffic.
module adc_conversion_frame_decoder_top_test;
   import acfd_pkg::*;

   // Byte addresses of the layout registers.
   localparam logic [2:0] ADDR_STATUS_ENABLE = {REG_STATUS_ENABLE, 2'b00};
   localparam logic [2:0] ADDR_CRC_ENABLE    = {REG_CRC_ENABLE, 2'b00};

   // Cycles that a stalled receiver holds rsp_tready low.
   localparam int HOLD_CYCLES = 80;

   localparam result_type NO_RESULT = '0;

   // Kinds of row in the directed table.
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_CRC_GOOD,
      ROW_CRC_BAD,
      ROW_LAYOUT
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         first;
      logic         cmd;
      logic         se;
      logic         ce;
      logic         typed;
      result_type   want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] rx_byte
   logic [1:0]  req_tuser = '0;   // [0] frame_first, [1] command_read
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [23:0] sample, [31:24] status_byte
   logic        rsp_tuser;        // [0] result_code
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Frame layout as the decoder has been told it.
   logic        cfg_status_en = 1'b0;
   logic        cfg_crc_en = 1'b0;

   // Frame tracking state of the predictor.
   logic [2:0]  fr_pos = '0;
   logic        fr_mode = 1'b0;
   logic [7:0]  fr_crc = '0;
   logic [23:0] fr_shift = '0;
   logic [7:0]  fr_pending = '0;
   logic [7:0]  fr_stored = '0;

   result_type  awaited[$];
   int          fault_count = 0;
   int          bytes_sent = 0;
   bit          req_gaps = 1'b1;
   bit          rsp_gaps = 1'b1;
   int          hold_asked = 0;
   int          hold_served = 0;
   int          hold_left = 0;

   // Directed frames: extremes of the sample, command-read frames, CRC pass and fail,
   // bytes ahead of any frame start and past a frame end, and a layout change mid-frame.
   plan_row_type plan [28] = '{
      '{ROW_BYTE,     8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h34, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h56, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '{8'h00, 24'h123456, RESULT_OK}},
      '{ROW_BYTE,     8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '{8'h00, 24'h7FFFFF, RESULT_OK}},
      '{ROW_BYTE,     8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h80, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '{8'h00, 24'h800000, RESULT_OK}},
      '{ROW_LAYOUT,   8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h11, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h22, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h33, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CRC_GOOD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CRC_BAD,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        '{8'h5A, 24'h000000, RESULT_CRC_MISMATCH}},
      '{ROW_LAYOUT,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LAYOUT,   8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{ROW_BYTE,     8'h03, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_CRC_GOOD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT}
   };

   adc_conversion_frame_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Guard against a hung handshake.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // CRC-8 over one byte, polynomial 0x07, fed bit by bit from the top.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      int         i;
      c = crc;
      for (i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   // Advances the frame tracker by one accepted byte; queues the frame result when it
   // completes and tells whether it did.
   function automatic bit decode_rx_byte(input logic [7:0] b, input logic first,
                                         input logic cmd);
      logic [2:0] p;
      logic [2:0] q;
      logic [2:0] d;
      result_type r;
      bit         done;
      if (first) begin
         fr_pos = '0;
         fr_mode = cmd;
         fr_crc = '0;
         fr_shift = '0;
      end
      p = fr_pos;
      if (fr_pos != POS_LAST) begin
         fr_pos = fr_pos + 3'd1;
      end
      // The leading byte of a command-read frame is dropped.
      if (p < {2'b00, fr_mode}) begin
         return 1'b0;
      end
      q = p - {2'b00, fr_mode};
      if (cfg_status_en && q == 3'd0) begin
         fr_pending = b;
         fr_crc = crc8_next(fr_crc, b);
         return 1'b0;
      end
      d = q - {2'b00, cfg_status_en};
      done = 1'b0;
      r = NO_RESULT;
      r.result_code = RESULT_OK;
      if (d < 3'd3) begin
         fr_shift = {fr_shift[15:0], b};
         fr_crc = crc8_next(fr_crc, b);
         done = (d == 3'd2) && !cfg_crc_en;
      end else if (d == 3'd3 && cfg_crc_en) begin
         done = 1'b1;
         if (b != fr_crc) begin
            r.result_code = RESULT_CRC_MISMATCH;
         end
      end
      if (!done) begin
         return 1'b0;
      end
      // A failed CRC zeroes the sample and leaves the stored status alone.
      if (r.result_code == RESULT_OK) begin
         if (cfg_status_en) begin
            fr_stored = fr_pending;
         end
         r.sample = fr_shift;
      end else begin
         r.sample = '0;
      end
      r.status_byte = fr_stored;
      awaited.push_back(r);
      return 1'b1;
   endfunction

   // Offers one byte, with random gaps ahead of it, and tracks it once the transfer completes.
   task automatic send_rx_byte(input logic [7:0] b, input logic first, input logic cmd,
                               output bit emitted);
      while (req_gaps && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {cmd, first};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      bytes_sent++;
      emitted = decode_rx_byte(b, first, cmd);
   endtask

   // Stops offering bytes and waits until every queued result has arrived.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reads a register back and compares it with the value written.
   task automatic csr_check(input logic [2:0] addr, input logic [31:0] expected);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== expected) begin
         $display("%0t: register at %h expected %h actual %h", $time, addr, expected, got);
         fault_count++;
      end
   endtask

   task automatic write_layout(input logic se, input logic ce);
      csr_write(ADDR_STATUS_ENABLE, {31'b0, se});
      csr_write(ADDR_CRC_ENABLE, {31'b0, ce});
      cfg_status_en = se;
      cfg_crc_en = ce;
      csr_check(ADDR_STATUS_ENABLE, {31'b0, se});
      csr_check(ADDR_CRC_ENABLE, {31'b0, ce});
   endtask

   // Result side: check each transfer against the oldest expectation, then decide the
   // next cycle's rsp_tready from random gaps or a requested long hold-off.
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited.size() == 0) begin
            $display("%0t: result %h code %b arrived with nothing expected",
                     $time, rsp_tdata, rsp_tuser);
            fault_count++;
         end else begin
            want = awaited.pop_front();
            if (rsp_tdata[23:0] !== want.sample) begin
               $display("%0t: sample expected %h actual %h",
                        $time, want.sample, rsp_tdata[23:0]);
               fault_count++;
            end
            if (rsp_tdata[31:24] !== want.status_byte) begin
               $display("%0t: status byte expected %h actual %h",
                        $time, want.status_byte, rsp_tdata[31:24]);
               fault_count++;
            end
            if (rsp_tuser !== want.result_code) begin
               $display("%0t: result code expected %b actual %b",
                        $time, want.result_code, rsp_tuser);
               fault_count++;
            end
         end
      end
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(rsp_gaps && $urandom_range(0, 99) < 25);
      end
   end

   initial begin
      plan_row_type row;
      logic [7:0]   value;
      bit           emitted;
      int           i;
      int           ph;
      int           k;
      int           start;
      int           pick;
      int           body;
      logic         lead;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_layout(1'b0, 1'b0);

      // Directed table.
      for (i = 0; i < 28; i++) begin
         row = plan[i];
         case (row.kind)
            ROW_LAYOUT: begin
               wait_until_idle();
               write_layout(row.se, row.ce);
            end
            default: begin
               value = row.value;
               if (row.kind == ROW_CRC_GOOD) begin
                  value = fr_crc;
               end else if (row.kind == ROW_CRC_BAD) begin
                  value = fr_crc ^ 8'hFF;
               end
               send_rx_byte(value, row.first, row.cmd, emitted);
               if (row.typed) begin
                  if (emitted) begin
                     void'(awaited.pop_back());
                  end
                  awaited.push_back(row.want);
               end
            end
         endcase
      end

      // Random phases, one layout each; phase 4 stalls the receiver against a busy
      // sender, phase 7 runs without any gaps.
      for (ph = 0; ph < 12; ph++) begin
         wait_until_idle();
         write_layout(ph[1], ph[0]);
         req_gaps = (ph != 4) && (ph != 7);
         rsp_gaps <= (ph != 7);
         if (ph == 4) begin
            hold_asked <= hold_asked + 1;
         end
         start = bytes_sent;
         while (bytes_sent - start < 106) begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
               // Well-formed frame with random content, sometimes a bad CRC or a tail.
               lead = 1'($urandom_range(0, 1));
               body = int'(lead) + int'(cfg_status_en) + 3;
               for (k = 0; k < body; k++) begin
                  send_rx_byte(8'($urandom_range(0, 255)), k == 0,
                               (k == 0) ? lead : 1'($urandom_range(0, 1)), emitted);
               end
               if (cfg_crc_en) begin
                  value = fr_crc;
                  if ($urandom_range(0, 4) == 0) begin
                     value = value ^ 8'($urandom_range(1, 255));
                  end
                  send_rx_byte(value, 1'b0, 1'($urandom_range(0, 1)), emitted);
               end
               if ($urandom_range(0, 9) == 0) begin
                  repeat ($urandom_range(1, 3)) begin
                     send_rx_byte(8'($urandom_range(0, 255)), 1'b0,
                                  1'($urandom_range(0, 1)), emitted);
                  end
               end
            end else begin
               // Noise and broken frames.
               repeat ($urandom_range(1, 6)) begin
                  send_rx_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                               1'($urandom_range(0, 1)), emitted);
               end
            end
         end
      end

      // Drain, then keep the clock running for any stray result.
      req_tvalid <= 1'b0;
      i = 0;
      while (awaited.size() != 0 && i < 20000) begin
         @(posedge clock);
         i++;
      end
      repeat (8) @(posedge clock);
      if (awaited.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/acfd_pkg.sv
rtl/acfd_frame_parser.sv
rtl/adc_conversion_frame_decoder_top.sv
rtl/acfd_checker.sv
tb/adc_conversion_frame_decoder_top_test.sv
